// File: src/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// shared opcodes, constants and controller/datapath interface structs
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int OP_W = 3;
    localparam int BYTE_W = 8;
    localparam int PAT_W = 32;

    localparam logic [OP_W-1:0] OP_PUSH_NEWEST = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_OLDEST  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK    = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR       = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT  = 3'd4;

    // byte returned by a pop or peek on an empty buffer
    localparam logic [BYTE_W-1:0] DOUT_EMPTY = 8'hFF;
    // number of newest bytes checked against the pattern
    localparam int LAST_N = 4;

    // controller to datapath
    typedef struct packed {
        logic accept;   // capture the incoming transaction
        logic exec;     // perform the operation, start checks
        logic rd_l4a;   // read the two oldest of the newest four
        logic rd_l4b;   // read the two newest
        logic rd_half;  // read one pair for the halves check
        logic ld_out;   // load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic idx_done; // all pairs of the halves check issued
    } t_stat;

endpackage

// File: src/byte_history_ring_buffer.sv
// ----------------------------------------------------------------------------
// byte_history_ring_buffer
// byte ring buffer that overwrites its oldest entry, with pattern and
// halves checks reported on every result
// ----------------------------------------------------------------------------
// one transaction at a time: an op is taken only while the sequencer is idle,
// and every op returns exactly one result. the time an op takes is set by
// the halves check, which walks the held bytes one pair per cycle through the
// two read ports of the byte store; the newest four bytes are read as two
// further pairs on the same ports. a new op may be accepted while the
// previous result still waits on a stalled output; the sequencer then holds
// the finished result in its finish state until the output register frees.
// the pattern register may only be written while no op is in flight. pops
// leave the byte in the store, and clear only resets pointers and count
// since bytes outside the held range are never read.
// ----------------------------------------------------------------------------
module byte_history_ring_buffer #(
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config transaction: pattern, oldest byte in bits 31:24
    input  logic                                i_cfg_we,
    input  logic [brb_pkg::PAT_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [brb_pkg::OP_W-1:0]            i_op,
    input  logic [brb_pkg::BYTE_W-1:0]          i_data_in,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [brb_pkg::BYTE_W-1:0]          o_data_out,
    output logic                                o_fault,
    output logic [$clog2(DEPTH+1)-1:0]          o_count,
    output logic                                o_last_four_match,
    output logic                                o_halves_equal
);

    brb_pkg::t_cmd  cmd;
    brb_pkg::t_stat stat;

    // sequencer: execute, two pattern reads, halves walk, drain, result load
    brb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // store, pointers, compare stage and result register
    brb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_data_in         (i_data_in),
        .o_data_out        (o_data_out),
        .o_fault           (o_fault),
        .o_count           (o_count),
        .o_last_four_match (o_last_four_match),
        .o_halves_equal    (o_halves_equal)
    );

endmodule

// File: src/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// sequencer for one transaction: execute, pattern reads, halves walk, result
// ----------------------------------------------------------------------------
module brb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  brb_pkg::t_stat i_stat,
    output brb_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_L4A,
        S_L4B,
        S_HALF,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        o_cmd         = '0;
        o_cmd.accept  = (r_state == S_IDLE) && i_valid;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.rd_l4a  = (r_state == S_L4A);
        o_cmd.rd_l4b  = (r_state == S_L4B);
        o_cmd.rd_half = (r_state == S_HALF) && !i_stat.idx_done;
        o_cmd.ld_out  = (r_state == S_FINISH) && out_free;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC:  n_state = S_L4A;
            S_L4A:   n_state = S_L4B;
            S_L4B:   n_state = S_HALF;
            S_HALF: begin
                if (i_stat.idx_done) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // a result must never overwrite one still waiting downstream
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_out |-> !(r_out_valid && i_stall))
        else $error("result loaded over a pending result");

    // an accepted transaction is executed in the very next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_cmd.exec)
        else $error("accepted transaction not executed");

    // a freshly loaded result is presented on the next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_out |=> o_valid)
        else $error("loaded result not presented");

endmodule

// File: src/brb_dp.sv
// ----------------------------------------------------------------------------
// brb_dp
// byte store, pointers, count, pattern register, compare stage and result
// ----------------------------------------------------------------------------
module brb_dp #(
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  brb_pkg::t_cmd                       i_cmd,
    output brb_pkg::t_stat                      o_stat,
    input  logic                                i_cfg_we,
    input  logic [brb_pkg::PAT_W-1:0]           i_cfg_data,
    input  logic [brb_pkg::OP_W-1:0]            i_op,
    input  logic [brb_pkg::BYTE_W-1:0]          i_data_in,
    output logic [brb_pkg::BYTE_W-1:0]          o_data_out,
    output logic                                o_fault,
    output logic [$clog2(DEPTH+1)-1:0]          o_count,
    output logic                                o_last_four_match,
    output logic                                o_halves_equal
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW:0]   DEPTH_W = (PW+1)'(DEPTH);
    localparam logic [PW-1:0] LAST_P  = (PW)'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_C  = (CW)'(DEPTH);
    localparam logic [PW:0]   L4_BASE = DEPTH_W - (PW+1)'(brb_pkg::LAST_N);

    typedef enum logic [2:0] {
        TAG_NONE,
        TAG_POP,
        TAG_L4A,
        TAG_L4B,
        TAG_HALF
    } t_tag;

    logic [brb_pkg::BYTE_W-1:0] r_mem [DEPTH];

    logic [brb_pkg::OP_W-1:0]   r_op;
    logic [brb_pkg::BYTE_W-1:0] r_din;
    logic [brb_pkg::PAT_W-1:0]  r_pattern;
    logic [PW-1:0]              r_front;
    logic [PW-1:0]              r_back;
    logic [CW-1:0]              r_count;
    logic [PW-1:0]              r_idx;
    t_tag                       r_tag;
    t_tag                       n_tag;
    logic [brb_pkg::BYTE_W-1:0] r_rd_a;
    logic [brb_pkg::BYTE_W-1:0] r_rd_b;
    logic                       r_l4_ok;
    logic                       r_half_ok;
    logic [brb_pkg::BYTE_W-1:0] r_dout;
    logic                       r_fault;

    logic [PW-1:0] addr_a;
    logic [PW-1:0] addr_b;
    logic [PW-1:0] front_p1;
    logic [PW-1:0] back_p1;
    logic [PW-1:0] back_m1;
    logic [CW-1:0] half;
    logic          empty;
    logic          rd_op;
    logic          mem_we;

    function automatic logic [PW-1:0] wrap_addr(input logic [PW:0] s);
        return (s >= DEPTH_W) ? (PW)'(s - DEPTH_W) : s[PW-1:0];
    endfunction

    assign front_p1 = (r_front == LAST_P) ? '0 : r_front + 1'b1;
    assign back_p1  = (r_back == LAST_P) ? '0 : r_back + 1'b1;
    assign back_m1  = (r_back == '0) ? LAST_P : r_back - 1'b1;
    assign half     = {1'b0, r_count[CW-1:1]};
    assign empty    = (r_count == '0);
    assign rd_op    = (r_op == brb_pkg::OP_POP_OLDEST) || (r_op == brb_pkg::OP_POP_BACK)
                   || (r_op == brb_pkg::OP_PEEK_FRONT);
    assign mem_we   = i_cmd.exec && (r_op == brb_pkg::OP_PUSH_NEWEST);

    assign o_stat.idx_done = ((CW)'(r_idx) >= half);

    // read address selection for the two read ports
    always_comb begin
        addr_a = r_front;
        addr_b = r_front;
        if (i_cmd.exec) begin
            addr_a = (r_op == brb_pkg::OP_POP_BACK) ? back_m1 : r_front;
        end else if (i_cmd.rd_l4a) begin
            addr_a = wrap_addr({1'b0, r_back} + L4_BASE);
            addr_b = wrap_addr({1'b0, r_back} + L4_BASE + (PW+1)'(1));
        end else if (i_cmd.rd_l4b) begin
            addr_a = wrap_addr({1'b0, r_back} + L4_BASE + (PW+1)'(2));
            addr_b = wrap_addr({1'b0, r_back} + L4_BASE + (PW+1)'(3));
        end else begin
            addr_a = wrap_addr({1'b0, r_front} + {1'b0, r_idx});
            addr_b = wrap_addr({1'b0, r_front} + {1'b0, r_idx} + (PW+1)'(half));
        end
    end

    always_comb begin
        n_tag = TAG_NONE;
        if (i_cmd.exec && rd_op && !empty) begin
            n_tag = TAG_POP;
        end else if (i_cmd.rd_l4a) begin
            n_tag = TAG_L4A;
        end else if (i_cmd.rd_l4b) begin
            n_tag = TAG_L4B;
        end else if (i_cmd.rd_half) begin
            n_tag = TAG_HALF;
        end
    end

    // byte store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_back] <= r_din;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    // captured transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_op;
            r_din <= i_data_in;
        end
    end

    // pattern register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
        end else if (i_cfg_we) begin
            r_pattern <= i_cfg_data;
        end
    end

    // pointers, count and walk index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_tag   <= TAG_NONE;
        end else begin
            r_tag <= n_tag;
            if (i_cmd.exec) begin
                r_idx <= '0;
                case (r_op)
                    brb_pkg::OP_PUSH_NEWEST: begin
                        if (r_count == FULL_C) begin
                            r_front <= front_p1;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                        r_back <= back_p1;
                    end
                    brb_pkg::OP_POP_OLDEST: begin
                        if (!empty) begin
                            r_front <= front_p1;
                            r_count <= r_count - 1'b1;
                        end
                    end
                    brb_pkg::OP_POP_BACK: begin
                        if (!empty) begin
                            r_back  <= back_m1;
                            r_count <= r_count - 1'b1;
                        end
                    end
                    brb_pkg::OP_CLEAR: begin
                        r_front <= '0;
                        r_back  <= '0;
                        r_count <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.rd_half) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // compare stage, working on the registered reads of the cycle before
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_l4_ok   <= 1'b1;
            r_half_ok <= 1'b1;
            r_fault   <= rd_op && empty;
            r_dout    <= (rd_op && empty) ? brb_pkg::DOUT_EMPTY : '0;
        end else begin
            case (r_tag)
                TAG_POP: r_dout <= r_rd_a;
                TAG_L4A: begin
                    if (r_rd_a != r_pattern[31:24] || r_rd_b != r_pattern[23:16]) begin
                        r_l4_ok <= 1'b0;
                    end
                end
                TAG_L4B: begin
                    if (r_rd_a != r_pattern[15:8] || r_rd_b != r_pattern[7:0]) begin
                        r_l4_ok <= 1'b0;
                    end
                end
                TAG_HALF: begin
                    if (r_rd_a != r_rd_b) begin
                        r_half_ok <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            o_data_out        <= r_dout;
            o_fault           <= r_fault;
            o_count           <= r_count;
            o_last_four_match <= r_l4_ok && (r_count >= (CW)'(brb_pkg::LAST_N));
            o_halves_equal    <= r_half_ok;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_C)
        else $error("count beyond depth");

    // back pointer always sits count entries past the front
    a_ptr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wrap_addr({1'b0, r_front} + (PW+1)'(r_count)) == r_back)
        else $error("pointers and count disagree");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_half |-> ((CW)'(r_idx) < half))
        else $error("halves walk past the half point");

endmodule

// File: sim/byte_history_ring_buffer_test.sv
// ----------------------------------------------------------------------------
// byte_history_ring_buffer_test
// self-checking bench for the byte ring buffer: a behavioral copy of the
// ring predicts every result, directed tests cover the empty, full and
// pattern cases, and random traffic with random stalls on both channels
// runs under a sweep of pattern settings
// ----------------------------------------------------------------------------
module byte_history_ring_buffer_test;

    localparam int DEPTH = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // op codes the block treats as no operation
    localparam logic [brb_pkg::OP_W-1:0] OP_NOP_FIRST = 3'd5;
    localparam logic [brb_pkg::OP_W-1:0] OP_NOP_LAST  = 3'd7;

    localparam int IDLE_PERCENT    = 37;
    localparam int HOLDOFF_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES     = 100;
    localparam int PHASE_ITEMS     = 180;

    // one result transaction as the block reports it
    typedef struct packed {
        logic [brb_pkg::BYTE_W-1:0] data_out;
        logic                       fault;
        logic [CNT_W-1:0]           count;
        logic                       last_four;
        logic                       halves;
    } t_ring_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [brb_pkg::PAT_W-1:0]    i_cfg_data;
    logic                         i_valid;
    logic                         o_stall;
    logic [brb_pkg::OP_W-1:0]     i_op;
    logic [brb_pkg::BYTE_W-1:0]   i_data_in;
    logic                         o_valid;
    logic                         i_stall;
    logic [brb_pkg::BYTE_W-1:0]   o_data_out;
    logic                         o_fault;
    logic [CNT_W-1:0]             o_count;
    logic                         o_last_four_match;
    logic                         o_halves_equal;

    byte_history_ring_buffer #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_op              (i_op),
        .i_data_in         (i_data_in),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_data_out        (o_data_out),
        .o_fault           (o_fault),
        .o_count           (o_count),
        .o_last_four_match (o_last_four_match),
        .o_halves_equal    (o_halves_equal)
    );

    // predictor state: a plain copy of the ring
    logic [brb_pkg::BYTE_W-1:0] ring_mem [DEPTH];
    int                         ring_front;
    int                         ring_back;
    int                         ring_fill;
    logic [brb_pkg::PAT_W-1:0]  ring_pattern;

    t_ring_result      pending_results [$];
    int                errors;
    int                items_sent;
    int                idle_cycles = 0;
    logic              quiet;           // no idling on either side
    logic              holdoff_pending; // asks the receiver for a long hold

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic int wrap_up(int p);
        return (p + 1 >= DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int wrap_down(int p);
        return (p == 0) ? DEPTH - 1 : p - 1;
    endfunction

    function automatic logic [brb_pkg::BYTE_W-1:0] logical_byte(int i);
        return ring_mem[(ring_front + i) % DEPTH];
    endfunction

    function automatic logic [brb_pkg::BYTE_W-1:0] pattern_byte(int k);
        return ring_pattern[brb_pkg::PAT_W-1-8*k -: 8];
    endfunction

    // newest four bytes, oldest first, against the pattern
    function automatic logic newest_four_match();
        if (ring_fill < brb_pkg::LAST_N)
            return 1'b0;
        for (int k = 0; k < brb_pkg::LAST_N; k++) begin
            if (logical_byte(ring_fill - brb_pkg::LAST_N + k) != pattern_byte(k))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // element i against element i + fill/2, newest one skipped when odd
    function automatic logic halves_match();
        int half;
        half = ring_fill / 2;
        for (int i = 0; i < half; i++) begin
            if (logical_byte(i) != logical_byte(i + half))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic apply_ring_op(input logic [brb_pkg::OP_W-1:0] op,
                                 input logic [brb_pkg::BYTE_W-1:0] din,
                                 output t_ring_result res);
        logic [brb_pkg::BYTE_W-1:0] dout;
        logic                       flt;
        dout = '0;
        flt  = 1'b0;
        case (op)
            brb_pkg::OP_PUSH_NEWEST: begin
                ring_mem[ring_back] = din;
                // full: oldest byte is overwritten, count stays
                if (ring_fill >= DEPTH)
                    ring_front = wrap_up(ring_front);
                else
                    ring_fill++;
                ring_back = wrap_up(ring_back);
            end
            brb_pkg::OP_POP_OLDEST: begin
                if (ring_fill == 0) begin
                    dout = brb_pkg::DOUT_EMPTY;
                    flt  = 1'b1;
                end else begin
                    dout       = ring_mem[ring_front];
                    ring_front = wrap_up(ring_front);
                    ring_fill--;
                end
            end
            brb_pkg::OP_POP_BACK: begin
                if (ring_fill == 0) begin
                    dout = brb_pkg::DOUT_EMPTY;
                    flt  = 1'b1;
                end else begin
                    ring_back = wrap_down(ring_back);
                    dout      = ring_mem[ring_back];
                    ring_fill--;
                end
            end
            brb_pkg::OP_CLEAR: begin
                foreach (ring_mem[i])
                    ring_mem[i] = '0;
                ring_front = 0;
                ring_back  = 0;
                ring_fill  = 0;
            end
            brb_pkg::OP_PEEK_FRONT: begin
                if (ring_fill == 0) begin
                    dout = brb_pkg::DOUT_EMPTY;
                    flt  = 1'b1;
                end else begin
                    dout = ring_mem[ring_front];
                end
            end
            default: begin
                // unused codes leave the ring alone
            end
        endcase
        res.data_out  = dout;
        res.fault     = flt;
        res.count     = CNT_W'(ring_fill);
        res.last_four = newest_four_match();
        res.halves    = halves_match();
    endtask

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offer one transaction, wait for acceptance, record its prediction;
    // entered and left at a falling edge with valid possibly still high
    task automatic offer_op(input logic [brb_pkg::OP_W-1:0] op,
                            input logic [brb_pkg::BYTE_W-1:0] din);
        t_ring_result res;
        int           gap;
        if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            // mostly short gaps, now and then one longer than a whole op
            gap = ($urandom_range(3) == 0) ? $urandom_range(48, 1) : $urandom_range(4, 1);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_op      <= op;
        i_data_in <= din;
        do
            @(posedge i_clk);
        while (o_stall !== 1'b0);
        apply_ring_op(op, din, res);
        pending_results.insert(pending_results.size(), res);
        items_sent++;
        @(negedge i_clk);
    endtask

    // sender stops offering and waits until every result is back
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // pattern register is only written with nothing in flight
    task automatic write_pattern(input logic [brb_pkg::PAT_W-1:0] value);
        wait_results_drained();
        i_cfg_we     <= 1'b1;
        i_cfg_data   <= value;
        ring_pattern = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // bytes biased toward the pattern and the extremes so matches happen
    function automatic logic [brb_pkg::BYTE_W-1:0] biased_byte();
        int pick;
        pick = $urandom_range(9);
        if (pick < 3)
            return pattern_byte($urandom_range(brb_pkg::LAST_N - 1));
        if (pick == 3)
            return $urandom_range(1) ? 8'h00 : 8'hFF;
        return (brb_pkg::BYTE_W)'($urandom_range(255));
    endfunction

    function automatic logic [brb_pkg::OP_W-1:0] any_pop();
        return $urandom_range(1) ? brb_pkg::OP_POP_OLDEST : brb_pkg::OP_POP_BACK;
    endfunction

    // ------------------------------------------------------------------------
    // output side: random stall, long hold on request
    // ------------------------------------------------------------------------
    initial begin : result_stall_driver
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_pending) begin
                holdoff_pending = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(negedge i_clk);
            end
            i_stall <= quiet ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // every accepted result against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_ring_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, data_out %0d count %0d",
                         $time, o_data_out, o_count);
                errors++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_data_out !== want.data_out) begin
                    $display("%0t: data_out expected %0d actual %0d",
                             $time, want.data_out, o_data_out);
                    errors++;
                end
                if (o_fault !== want.fault) begin
                    $display("%0t: fault expected %0d actual %0d",
                             $time, want.fault, o_fault);
                    errors++;
                end
                if (o_count !== want.count) begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, want.count, o_count);
                    errors++;
                end
                if (o_last_four_match !== want.last_four) begin
                    $display("%0t: last_four_match expected %0d actual %0d",
                             $time, want.last_four, o_last_four_match);
                    errors++;
                end
                if (o_halves_equal !== want.halves) begin
                    $display("%0t: halves_equal expected %0d actual %0d",
                             $time, want.halves, o_halves_equal);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles in a row with no transaction on either channel
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // pops and peek on an empty ring fault, unused codes do nothing
    task automatic test_empty_buffer();
        offer_op(brb_pkg::OP_POP_OLDEST, 8'h00);
        offer_op(brb_pkg::OP_POP_BACK, 8'hFF);
        offer_op(brb_pkg::OP_PEEK_FRONT, 8'h5A);
        for (int op = OP_NOP_FIRST; op <= OP_NOP_LAST; op++)
            offer_op((brb_pkg::OP_W)'(op), 8'hA5);
    endtask

    // newest four against the pattern, kept in logical order across pops
    task automatic test_pattern_match();
        write_pattern(32'hDEAD_BEEF);
        offer_op(brb_pkg::OP_PUSH_NEWEST, 8'h00);
        offer_op(brb_pkg::OP_PUSH_NEWEST, 8'hFF);
        offer_op(brb_pkg::OP_PUSH_NEWEST, 8'hDE);
        offer_op(brb_pkg::OP_PUSH_NEWEST, 8'hAD);
        offer_op(brb_pkg::OP_PUSH_NEWEST, 8'hBE);
        offer_op(brb_pkg::OP_PUSH_NEWEST, 8'hEF);
        offer_op(brb_pkg::OP_PEEK_FRONT, 8'h00);
        offer_op(brb_pkg::OP_POP_OLDEST, 8'h00);
        offer_op(brb_pkg::OP_POP_BACK, 8'h00);
        offer_op(brb_pkg::OP_PUSH_NEWEST, 8'hEF);
        offer_op(brb_pkg::OP_CLEAR, 8'hFF);
    endtask

    // equal halves, odd count with the newest byte ignored, pops down to two bytes
    task automatic test_halves_directed();
        offer_op(brb_pkg::OP_PUSH_NEWEST, 8'h11);
        offer_op(brb_pkg::OP_PUSH_NEWEST, 8'h22);
        offer_op(brb_pkg::OP_PUSH_NEWEST, 8'h11);
        offer_op(brb_pkg::OP_PUSH_NEWEST, 8'h22);
        offer_op(brb_pkg::OP_PUSH_NEWEST, 8'h33);
        offer_op(brb_pkg::OP_POP_OLDEST, 8'h00);
        offer_op(brb_pkg::OP_POP_OLDEST, 8'h00);
        offer_op(brb_pkg::OP_POP_OLDEST, 8'h00);
    endtask

    // fill to the brim, pop back across the pointer wrap, then overwrite
    task automatic test_full_overwrite();
        offer_op(brb_pkg::OP_CLEAR, 8'h00);
        repeat (DEPTH) offer_op(brb_pkg::OP_PUSH_NEWEST, biased_byte());
        offer_op(brb_pkg::OP_POP_BACK, 8'h00);
        repeat (8) offer_op(brb_pkg::OP_PUSH_NEWEST, biased_byte());
        repeat (3) offer_op(brb_pkg::OP_POP_OLDEST, 8'h00);
        offer_op(brb_pkg::OP_PEEK_FRONT, 8'h00);
    endtask

    // receiver holds off while the sender keeps offering, so the block
    // backs up and stalls its input
    task automatic test_output_holdoff();
        holdoff_pending = 1'b1;
        repeat (12) offer_op(brb_pkg::OP_PUSH_NEWEST, biased_byte());
        wait_results_drained();
    endtask

    // mostly well-formed sequences with random content, some noise
    task automatic test_random_traffic(input int n_items);
        logic [brb_pkg::BYTE_W-1:0] mirror_bytes [12];
        int                         stop_at;
        int                         len;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    // pattern at the tail, then one random op
                    repeat ($urandom_range(3))
                        offer_op(brb_pkg::OP_PUSH_NEWEST, biased_byte());
                    for (int k = 0; k < brb_pkg::LAST_N; k++)
                        offer_op(brb_pkg::OP_PUSH_NEWEST, pattern_byte(k));
                    offer_op((brb_pkg::OP_W)'($urandom_range(OP_NOP_LAST)),
                             (brb_pkg::BYTE_W)'($urandom_range(255)));
                end
                3, 4: begin
                    // a block pushed twice, sometimes from empty
                    if ($urandom_range(1))
                        offer_op(brb_pkg::OP_CLEAR, (brb_pkg::BYTE_W)'($urandom_range(255)));
                    len = $urandom_range(12, 1);
                    for (int i = 0; i < len; i++)
                        mirror_bytes[i] = biased_byte();
                    for (int i = 0; i < 2 * len; i++)
                        offer_op(brb_pkg::OP_PUSH_NEWEST, mirror_bytes[i % len]);
                    if ($urandom_range(1))
                        offer_op(brb_pkg::OP_PUSH_NEWEST, biased_byte());
                    offer_op(any_pop(), (brb_pkg::BYTE_W)'($urandom_range(255)));
                end
                5: begin
                    // past full, then a few pops
                    repeat (DEPTH + $urandom_range(8))
                        offer_op(brb_pkg::OP_PUSH_NEWEST, biased_byte());
                    repeat ($urandom_range(6, 1)) offer_op(any_pop(), biased_byte());
                end
                6: begin
                    // drain to empty and one more to fault
                    while (ring_fill > 0)
                        offer_op(any_pop(), (brb_pkg::BYTE_W)'($urandom_range(255)));
                    offer_op($urandom_range(1) ? any_pop() : brb_pkg::OP_PEEK_FRONT,
                             biased_byte());
                end
                default: begin
                    // noise over every op code
                    repeat ($urandom_range(10, 1))
                        offer_op((brb_pkg::OP_W)'($urandom_range(OP_NOP_LAST)),
                                 (brb_pkg::BYTE_W)'($urandom_range(255)));
                end
            endcase
        end
    endtask

    // pattern settings from both extremes and random values, each followed
    // by random traffic; the sender drains before every write
    task automatic test_pattern_sweep();
        logic [brb_pkg::PAT_W-1:0] setting;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       setting = '0;
                1:       setting = '1;
                2:       setting = {4{(brb_pkg::BYTE_W)'($urandom_range(255))}};
                default: setting = $urandom;
            endcase
            write_pattern(setting);
            // one phase runs with no idling at all
            quiet = (phase == 3);
            test_random_traffic(PHASE_ITEMS);
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_op            = brb_pkg::OP_PUSH_NEWEST;
        i_data_in       = '0;
        quiet           = 1'b0;
        holdoff_pending = 1'b0;
        errors          = 0;
        items_sent      = 0;
        ring_front      = 0;
        ring_back       = 0;
        ring_fill       = 0;
        ring_pattern    = '0;
        foreach (ring_mem[i])
            ring_mem[i] = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_buffer();
        test_pattern_match();
        test_halves_directed();
        test_full_overwrite();
        test_output_holdoff();
        test_pattern_sweep();

        // all results in, then a quiet tail to catch strays
        wait_results_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (errors == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
